>>> rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int ENTRY_W = 32;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic               func;
    logic [15:0]        task_id;
    logic signed [15:0] task_priority;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_task_id;
    logic signed [15:0] out_priority;
    logic [1:0]         status;
    logic [6:0]         entries;
  } out_item_t;

  // One heap entry: identifier in the upper half, priority in the lower half.
  typedef struct packed {
    logic [15:0]        id;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_stat_t;

endpackage

>>> rtl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/mhpq_engine.sv
// ----------------------------------------------------------------------------
// mhpq_engine
// Sequencer that runs insert (sift-up) and extract (sift-down) against the
// heap RAM, keeping the moving entry in a register and writing only once
// per level.
// ----------------------------------------------------------------------------
module mhpq_engine import mhpq_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int XW = AW + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  in_item_t           in_item,
  input  logic               res_take,
  output eng_stat_t          stat,
  output out_item_t          result,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [ENTRY_W-1:0] wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [ENTRY_W-1:0] rd_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_UP   = 4'd1;
  localparam logic [3:0] S_INS_CMP  = 4'd2;
  localparam logic [3:0] S_EXT_TOP  = 4'd3;
  localparam logic [3:0] S_EXT_LAST = 4'd4;
  localparam logic [3:0] S_EXT_LOAD = 4'd5;
  localparam logic [3:0] S_EXT_DN   = 4'd6;
  localparam logic [3:0] S_EXT_LEFT = 4'd7;
  localparam logic [3:0] S_EXT_CMP  = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  entry_t             elem_r, elem_nxt;
  entry_t             left_r, left_nxt;
  logic               right_ok_r, right_ok_nxt;
  logic [15:0]        res_id_r, res_id_nxt;
  logic signed [15:0] res_prio_r, res_prio_nxt;
  logic [1:0]         status_r, status_nxt;

  entry_t             rd_entry;
  logic [AW-1:0]      parent_idx;
  logic [XW-1:0]      left_idx;
  logic [XW-1:0]      right_idx;
  logic [XW-1:0]      n_ext;
  logic               take_left;
  logic signed [15:0] best_prio;
  logic               take_right;

  assign rd_entry   = entry_t'(rd_data);
  assign parent_idx = (pos_r - AW'(1)) >> 1;
  assign left_idx   = XW'({pos_r, 1'b1});
  assign right_idx  = left_idx + XW'(1);
  assign n_ext      = XW'(count_r);

  // Largest of the moving entry and its children; left wins a tie.
  assign take_left  = $signed(elem_r.prio) < $signed(left_r.prio);
  assign best_prio  = take_left ? left_r.prio : elem_r.prio;
  assign take_right = right_ok_r && ($signed(best_prio) < $signed(rd_entry.prio));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    elem_nxt     = elem_r;
    left_nxt     = left_r;
    right_ok_nxt = right_ok_r;
    res_id_nxt   = res_id_r;
    res_prio_nxt = res_prio_r;
    status_nxt   = status_r;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    wr_data      = elem_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          elem_nxt.id   = in_item.task_id;
          elem_nxt.prio = in_item.task_priority;
          res_id_nxt    = '0;
          res_prio_nxt  = '0;
          status_nxt    = STATUS_DONE;
          if (in_item.func == FUNC_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              status_nxt = STATUS_FULL;
              state_nxt  = S_FIN;
            end else begin
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = S_INS_UP;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STATUS_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_EXT_TOP;
            end
          end
        end
      end
      S_INS_UP: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = parent_idx;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if ($signed(rd_entry.prio) < $signed(elem_r.prio)) begin
          // Parent moves down into the hole; the hole moves up.
          wr_data   = rd_data;
          pos_nxt   = parent_idx;
          state_nxt = S_INS_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EXT_TOP: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = S_EXT_LAST;
      end
      S_EXT_LAST: begin
        res_id_nxt   = rd_entry.id;
        res_prio_nxt = rd_entry.prio;
        if (count_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = count_r[AW-1:0];
          state_nxt = S_EXT_LOAD;
        end
      end
      S_EXT_LOAD: begin
        elem_nxt  = rd_entry;
        pos_nxt   = '0;
        state_nxt = S_EXT_DN;
      end
      S_EXT_DN: begin
        if (left_idx >= n_ext) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = left_idx[AW-1:0];
          state_nxt = S_EXT_LEFT;
        end
      end
      S_EXT_LEFT: begin
        left_nxt     = rd_entry;
        right_ok_nxt = right_idx < n_ext;
        if (right_idx < n_ext) begin
          rd_en   = 1'b1;
          rd_addr = right_idx[AW-1:0];
        end
        state_nxt = S_EXT_CMP;
      end
      S_EXT_CMP: begin
        wr_en = 1'b1;
        if (take_right) begin
          wr_data   = rd_data;
          pos_nxt   = right_idx[AW-1:0];
          state_nxt = S_EXT_DN;
        end else if (take_left) begin
          wr_data   = left_r;
          pos_nxt   = left_idx[AW-1:0];
          state_nxt = S_EXT_DN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    elem_r     <= elem_nxt;
    left_r     <= left_nxt;
    right_ok_r <= right_ok_nxt;
    res_id_r   <= res_id_nxt;
    res_prio_r <= res_prio_nxt;
    status_r   <= status_nxt;
  end

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_FIN);

  assign result.out_task_id  = res_id_r;
  assign result.out_priority = res_prio_r;
  assign result.status       = status_r;
  assign result.entries      = 7'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("heap count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("read and write of the same heap entry in one cycle");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    start && state_r == S_IDLE && in_item.func == FUNC_INSERT && count_r < CW'(CAPACITY)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the heap by one");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE)
    else $error("item started while the engine was busy");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && !res_take
    |=> state_r == S_FIN && $stable(res_id_r) && $stable(status_r))
    else $error("pending result changed before it was taken");

endmodule

>>> rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of tasks keyed by signed priority, held in one RAM.
// ----------------------------------------------------------------------------
//   channel  ports                          carries
//   input    in_valid, in_ready, in_item    insert or extract request
//   result   out_valid, out_ready, out_item id, priority, status, entries
//
// One item is worked on at a time; each level of a sift costs RAM reads from
// the registered read port. An insert reads the parent at each level, an
// extract reads the root, the last entry and then the children at each level;
// an extract that empties the heap reads only the root, and a full or empty
// error reaches the result without RAM access. The engine is ready for the
// next item as soon as the result moves to the output register.
// Reset (rst_n, synchronous) empties the heap at once; RAM contents need none.
// A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int AW = $clog2(CAPACITY);

  eng_stat_t          stat;
  out_item_t          result;
  logic               start;
  logic               res_take;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;

  // The finished item moves to the output register once that slot is free.
  assign res_take = stat.res_valid && (!out_valid_r || out_ready);

  mhpq_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .res_take(res_take),
    .stat    (stat),
    .result  (result),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mhpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> dv/tb_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking testbench for the max-heap priority queue. A behavioural heap
// predicts each result when an item is accepted. The checker compares every
// result, field by field, with the oldest prediction. Directed items and a
// fill to overflow and drain to underflow cover corner cases, then one long
// output stall and random insert/extract phases run, gapped on both channels.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int HEAP_CAP     = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int QUIET_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Behavioural copy of the heap, updated as each item is accepted.
  entry_t    heap_model [HEAP_CAP];
  int        heap_fill = 0;
  out_item_t awaited_outcomes [$];

  int mismatch_count = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int hold_requests = 0;

  max_heap_priority_queue #(
    .CAPACITY(HEAP_CAP)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] rand_priority();
    int v;
    case ($urandom_range(0, 3))
      0: begin
        // A narrow band so that ties are frequent.
        v = $urandom_range(0, 6);
        return 16'(v - 3);
      end
      1: begin
        case ($urandom_range(0, 5))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          4: return 16'sh8001;
          default: return 16'sh7FFE;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Applies one request to the heap copy and returns the result it causes.
  function automatic out_item_t heap_apply(in_item_t req);
    out_item_t res;
    entry_t    tmp;
    int        pos;
    int        up;
    int        best;
    int        l;
    int        r;
    res = '0;
    if (req.func == FUNC_INSERT) begin
      if (heap_fill >= HEAP_CAP) begin
        res.status = STATUS_FULL;
      end else begin
        heap_model[heap_fill] = {req.task_id, req.task_priority};
        pos = heap_fill;
        heap_fill++;
        // A task moves up only past a strictly smaller parent.
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if ($signed(heap_model[up].prio) < $signed(heap_model[pos].prio)) begin
            tmp = heap_model[up];
            heap_model[up] = heap_model[pos];
            heap_model[pos] = tmp;
            pos = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.out_task_id  = heap_model[0].id;
        res.out_priority = heap_model[0].prio;
        heap_fill--;
        heap_model[0] = heap_model[heap_fill];
        pos = 0;
        // On equal children the left one wins, as it is tested first.
        while (pos < heap_fill) begin
          best = pos;
          l = 2 * pos + 1;
          r = 2 * pos + 2;
          if (l < heap_fill && $signed(heap_model[best].prio) < $signed(heap_model[l].prio))
            best = l;
          if (r < heap_fill && $signed(heap_model[best].prio) < $signed(heap_model[r].prio))
            best = r;
          if (best == pos) break;
          tmp = heap_model[best];
          heap_model[best] = heap_model[pos];
          heap_model[pos] = tmp;
          pos = best;
        end
      end
    end
    res.status  = res.status;
    res.entries = 7'(heap_fill);
    return res;
  endfunction

  // Offers one item and returns at the edge where it is accepted. The caller
  // must follow with another send or with wait_drained before the next edge.
  task automatic send_request(input logic func, input logic [15:0] id,
                              input logic signed [15:0] prio);
    int        gap;
    in_item_t  req;
    out_item_t outcome;
    gap = tx_calm ? 0 : pick_gap();
    req.func          = func;
    req.task_id       = id;
    req.task_priority = prio;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = req;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    outcome = heap_apply(req);
    awaited_outcomes = {awaited_outcomes, outcome};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_outcomes.size() > 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold whenever a test asks for one.
  initial begin
    int stall;
    int seen;
    int gap;
    stall = 0;
    seen  = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen) begin
        seen  = hold_requests;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        gap = rx_calm ? 0 : pick_gap();
        if (gap > 0) begin
          out_ready = 1'b0;
          stall = gap - 1;
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: id=%h prio=%0d status=%0d entries=%0d",
                   out_item.out_task_id, out_item.out_priority,
                   out_item.status, out_item.entries);
        mismatch_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_item.out_task_id !== want.out_task_id ||
            out_item.out_priority !== want.out_priority ||
            out_item.status !== want.status ||
            out_item.entries !== want.entries) begin
          if (mismatch_count < 10)
            $display({"mismatch: expected id=%h prio=%0d status=%0d entries=%0d,",
                      " got id=%h prio=%0d status=%0d entries=%0d"},
                     want.out_task_id, want.out_priority, want.status, want.entries,
                     out_item.out_task_id, out_item.out_priority,
                     out_item.status, out_item.entries);
          mismatch_count++;
        end
      end
    end
  end

  // Extremes of the fields, ties at the root and between children, and
  // extraction from an empty heap before any insert and after draining.
  task automatic test_directed();
    send_request(FUNC_EXTRACT, 16'h0000, 16'sh0000);
    send_request(FUNC_INSERT,  16'h0000, 16'sh8000);
    send_request(FUNC_INSERT,  16'hFFFF, 16'sh7FFF);
    send_request(FUNC_INSERT,  16'h1234, 16'sh0000);
    send_request(FUNC_INSERT,  16'h00FF, 16'shFFFF);
    send_request(FUNC_INSERT,  16'h8000, 16'sh7FFF);
    send_request(FUNC_INSERT,  16'h7FFF, 16'sh0005);
    send_request(FUNC_INSERT,  16'hAAAA, 16'sh0005);
    send_request(FUNC_INSERT,  16'h5555, 16'sh0005);
    send_request(FUNC_INSERT,  16'h0001, 16'sh8001);
    repeat (9) send_request(FUNC_EXTRACT, 16'hFFFF, 16'sh7FFF);
    send_request(FUNC_EXTRACT, 16'hFFFF, 16'shFFFF);
    send_request(FUNC_INSERT,  16'hC3C3, 16'sh0001);
    send_request(FUNC_EXTRACT, 16'h0000, 16'sh8000);
  endtask

  // Fills the heap to capacity, overflows it, then empties it and underflows.
  task automatic test_fill_and_overflow();
    while (heap_fill < HEAP_CAP)
      send_request(FUNC_INSERT, 16'($urandom), rand_priority());
    repeat (3) send_request(FUNC_INSERT, 16'($urandom), rand_priority());
    repeat (HEAP_CAP + 2) send_request(FUNC_EXTRACT, 16'($urandom), 16'($urandom));
  endtask

  // The receiver holds off while items keep coming, so the input must stall.
  task automatic test_output_stall();
    hold_requests++;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0)
        send_request(FUNC_EXTRACT, 16'($urandom), 16'($urandom));
      else
        send_request(FUNC_INSERT, 16'($urandom), rand_priority());
    end
    wait_drained();
  endtask

  // Phases biased toward filling, draining or balance, so that the heap swings
  // between empty and full with random content.
  task automatic test_random_mix(input int n_items);
    int   sent;
    int   phase_len;
    int   insert_pct;
    logic op;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) wait_drained();
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
        send_request(op, 16'($urandom), rand_priority());
        sent++;
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_and_overflow();
    test_output_stall();
    test_random_mix(1450);

    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_outcomes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_engine.sv
rtl/max_heap_priority_queue.sv
dv/tb_max_heap_priority_queue.sv
